### rtl/core/mtd_pkg.sv
// Shared types, symbol codes and the Morse code table for the text decoder.
`timescale 1ns / 1ps
package mtd_pkg;

  localparam logic [7:0] SYM_DOT  = 8'd46;
  localparam logic [7:0] SYM_DASH = 8'd45;
  localparam logic [7:0] SYM_GAP  = 8'd32;
  localparam logic [2:0] MAX_SYMS = 3'd6;

  typedef struct packed {
    logic [7:0] text_char;
    logic       word_end;
    logic       text_end;
  } text_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } result_item_t;

  // Work handed from the front to the back for one input beat.
  typedef struct packed {
    logic       glyph_valid;
    logic [7:0] glyph;
    logic       space;
  } cmd_t;

  // Symbol i of a code is bit i, dash = 1. Returns zero when no entry matches.
  function automatic logic [7:0] lookup_glyph(input logic [2:0] len, input logic [5:0] bits);
    logic [8:0] key;
    logic [7:0] g;
    key = {len, bits};
    unique case (key)
      {3'd2, 6'd2}:  g = 8'h61; // a
      {3'd4, 6'd1}:  g = 8'h62; // b
      {3'd4, 6'd5}:  g = 8'h63; // c
      {3'd3, 6'd1}:  g = 8'h64; // d
      {3'd1, 6'd0}:  g = 8'h65; // e
      {3'd4, 6'd4}:  g = 8'h66; // f
      {3'd3, 6'd3}:  g = 8'h67; // g
      {3'd4, 6'd0}:  g = 8'h68; // h
      {3'd2, 6'd0}:  g = 8'h69; // i
      {3'd4, 6'd14}: g = 8'h6a; // j
      {3'd3, 6'd5}:  g = 8'h6b; // k
      {3'd4, 6'd2}:  g = 8'h6c; // l
      {3'd2, 6'd3}:  g = 8'h6d; // m
      {3'd2, 6'd1}:  g = 8'h6e; // n
      {3'd3, 6'd7}:  g = 8'h6f; // o
      {3'd4, 6'd6}:  g = 8'h70; // p
      {3'd4, 6'd11}: g = 8'h71; // q
      {3'd3, 6'd2}:  g = 8'h72; // r
      {3'd3, 6'd0}:  g = 8'h73; // s
      {3'd1, 6'd1}:  g = 8'h74; // t
      {3'd3, 6'd4}:  g = 8'h75; // u
      {3'd4, 6'd8}:  g = 8'h76; // v
      {3'd3, 6'd6}:  g = 8'h77; // w
      {3'd4, 6'd9}:  g = 8'h78; // x
      {3'd4, 6'd13}: g = 8'h79; // y
      {3'd4, 6'd3}:  g = 8'h7a; // z
      {3'd6, 6'd42}: g = 8'h2e; // period
      {3'd6, 6'd51}: g = 8'h2c; // comma
      default:       g = 8'h00;
    endcase
    return g;
  endfunction

endpackage

### rtl/core/mtd_front.sv
// Front end: accepts characters, builds the code and classifies each beat.
`timescale 1ns / 1ps
module mtd_front import mtd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  text_item_t item,
  input  logic       q_full,
  output logic       cmd_push,
  output cmd_t       cmd,
  output logic [2:0] code_length
);

  logic [5:0] code_bits;
  logic       code_invalid;
  logic [5:0] code_bits_next;
  logic [2:0] code_length_next;
  logic       code_invalid_next;

  logic       accept;
  logic       is_dash;
  logic       is_sym;
  logic       is_gap;
  logic       close;
  logic [5:0] bits_app;
  logic [2:0] len_app;
  logic       inv_app;
  logic [7:0] glyph;

  assign accept  = push && !q_full;
  assign is_dash = (item.text_char == SYM_DASH);
  assign is_sym  = (item.text_char == SYM_DOT) || is_dash;
  assign is_gap  = (item.text_char == SYM_GAP);
  assign close   = is_gap || item.word_end || item.text_end;

  // Append the symbol of this beat before any close.
  always_comb begin
    bits_app = code_bits;
    len_app  = code_length;
    inv_app  = code_invalid;
    if (is_sym) begin
      if (code_length < MAX_SYMS) begin
        if (is_dash) begin
          bits_app = code_bits | (6'd1 << code_length);
        end
        len_app = code_length + 3'd1;
      end else begin
        inv_app = 1'b1;
      end
    end else if (!is_gap) begin
      inv_app = 1'b1;
    end
  end

  assign glyph = lookup_glyph(len_app, bits_app);

  always_comb begin
    cmd.glyph_valid = close && !inv_app && (len_app != 3'd0) && (glyph != 8'd0);
    cmd.glyph       = glyph;
    cmd.space       = item.word_end && !item.text_end;
  end

  // Beats that give no result leave nothing in the queue.
  assign cmd_push = accept && (cmd.glyph_valid || cmd.space);

  always_comb begin
    if (close) begin
      code_bits_next    = 6'd0;
      code_length_next  = 3'd0;
      code_invalid_next = 1'b0;
    end else begin
      code_bits_next    = bits_app;
      code_length_next  = len_app;
      code_invalid_next = inv_app;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_bits    <= 6'd0;
      code_length  <= 3'd0;
      code_invalid <= 1'b0;
    end else if (accept) begin
      code_bits    <= code_bits_next;
      code_length  <= code_length_next;
      code_invalid <= code_invalid_next;
    end
  end

endmodule

### rtl/core/mtd_cmd_queue.sv
// Short command queue between the front and the back.
`timescale 1ns / 1ps
module mtd_cmd_queue import mtd_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic full,
  input  logic rd_en,
  output logic empty,
  output cmd_t rd_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/core/mtd_back.sv
// Back end: expands commands into result beats through an output register.
`timescale 1ns / 1ps
module mtd_back import mtd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         q_empty,
  input  cmd_t         head,
  output logic         q_pop,
  input  logic         pop,
  output logic         empty,
  output result_item_t result,
  output logic         space_pending
);

  logic         out_valid;
  logic         load;
  logic         space_pending_next;
  result_item_t result_next;

  assign empty = !out_valid;
  assign load  = !out_valid || pop;

  always_comb begin
    q_pop              = 1'b0;
    space_pending_next = space_pending;
    result_next        = result;
    if (load && !q_empty) begin
      if (head.glyph_valid && !space_pending) begin
        result_next.out_char = head.glyph;
        result_next.last     = !head.space;
        // Hold the command when its word space still has to follow.
        if (head.space) begin
          space_pending_next = 1'b1;
        end else begin
          q_pop = 1'b1;
        end
      end else begin
        result_next.out_char = SYM_GAP;
        result_next.last     = 1'b1;
        space_pending_next   = 1'b0;
        q_pop                = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      space_pending <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= !q_empty;
      end
      space_pending <= space_pending_next;
    end
  end

endmodule

### rtl/core/morse_text_decoder_core.sv
// Streaming Morse text decoder: front classifier, command queue, result stage.
// A result reaches the result ports through the command queue and the output register.
// Input beats are taken one per cycle while the queue is not full; results leave at one
// per cycle while pop is high, so a beat with a letter and a word space gives two result beats.
// The command queue (QUEUE_DEPTH entries) sets how long the front runs on while pop is low.
// Reset (rst, synchronous): clears the code being built, the queue and the output stage.
`timescale 1ns / 1ps
module morse_text_decoder_core import mtd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  output logic         full,
  input  text_item_t   item,
  output logic         empty,
  input  logic         pop,
  output result_item_t result
);

  logic       cmd_push;
  cmd_t       cmd;
  logic [2:0] code_length;
  logic       q_full;
  logic       q_empty;
  logic       q_pop;
  cmd_t       q_head;
  logic       space_pending;

  assign full = q_full;

  mtd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .item        (item),
    .q_full      (q_full),
    .cmd_push    (cmd_push),
    .cmd         (cmd),
    .code_length (code_length)
  );

  mtd_cmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (cmd),
    .full    (q_full),
    .rd_en   (q_pop),
    .empty   (q_empty),
    .rd_data (q_head)
  );

  mtd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .head          (q_head),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .result        (result),
    .space_pending (space_pending)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> !q_full)
    else $error("command pushed into a full queue");

  a_space_has_cmd: assert property (@(posedge clk) disable iff (rst)
    space_pending |-> !q_empty)
    else $error("pending word space without a queued command");

  a_not_last_is_glyph: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.last) |-> (result.out_char != SYM_GAP))
    else $error("word space shown as a non-final beat");

  a_text_end_clears: assert property (@(posedge clk) disable iff (rst)
    (push && !full && item.text_end) |=> (code_length == 3'd0))
    else $error("code not cleared after text end");

endmodule

### tb/tb.sv
// Testbench for morse_text_decoder_core: directed and random Morse text, checked beat by beat.
`timescale 1ns / 1ps
module tb;
  import mtd_pkg::*;

  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned TAIL_CYCLES = 8;
  localparam int unsigned CODE_COUNT  = 28;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         push = 1'b0;
  logic         full;
  text_item_t   item = '0;
  logic         empty;
  logic         pop = 1'b0;
  result_item_t result;

  // Code table of the decoder, index k gives the glyph at position k.
  string morse_pattern [CODE_COUNT] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
    "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
    "..-", "...-", ".--", "-..-", "-.--", "--..", ".-.-.-", "--..--"};
  string morse_glyphs = "abcdefghijklmnopqrstuvwxyz.,";

  // Decoder state as predicted.
  logic [5:0] sym_bits  = '0;
  logic [2:0] sym_count = '0;
  logic       sym_bad   = 1'b0;

  result_item_t expected_chars [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatches    = 0;
  int unsigned stall_cycles  = 0;
  int unsigned beats_sent    = 0;
  int unsigned glyphs_seen   = 0;
  int unsigned spaces_seen   = 0;

  morse_text_decoder_core dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    pop = !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic [7:0] glyph_of(input logic [2:0] len, input logic [5:0] bits);
    logic [5:0] pat_bits;
    logic [7:0] g;
    string      p;
    int         k;
    int         n;
    g = 8'h00;
    for (k = 0; k < CODE_COUNT; k++) begin
      p = morse_pattern[k];
      pat_bits = '0;
      for (n = 0; n < p.len(); n++) begin
        if (p[n] == "-") pat_bits[n] = 1'b1;
      end
      if (p.len() == len && pat_bits == bits) g = morse_glyphs[k];
    end
    return g;
  endfunction

  // Advance the predicted decoder by one beat and queue the characters it yields.
  task automatic decode_beat(input text_item_t it);
    result_item_t out [2];
    logic         closing;
    logic [7:0]   g;
    int           cnt;
    int           i;
    closing = 1'b0;
    cnt = 0;
    if (it.text_char == SYM_DOT || it.text_char == SYM_DASH) begin
      if (sym_count < MAX_SYMS) begin
        if (it.text_char == SYM_DASH) sym_bits = sym_bits | (6'd1 << sym_count);
        sym_count = sym_count + 3'd1;
      end else begin
        sym_bad = 1'b1;
      end
    end else if (it.text_char == SYM_GAP) begin
      closing = 1'b1;
    end else begin
      sym_bad = 1'b1;
    end
    if (it.word_end || it.text_end) closing = 1'b1;
    if (closing) begin
      if (!sym_bad && sym_count != 0) begin
        g = glyph_of(sym_count, sym_bits);
        if (g != 8'h00) begin
          out[cnt] = '{out_char: g, last: 1'b0};
          cnt++;
        end
      end
      sym_bits = '0;
      sym_count = '0;
      sym_bad = 1'b0;
    end
    if (it.word_end && !it.text_end) begin
      out[cnt] = '{out_char: SYM_GAP, last: 1'b0};
      cnt++;
    end
    if (cnt > 0) out[cnt - 1].last = 1'b1;
    for (i = 0; i < cnt; i++) expected_chars.push_back(out[i]);
  endtask

  task automatic check_char(input result_item_t got);
    result_item_t want;
    if (expected_chars.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: unexpected beat out_char=%02h last=%b", $realtime, got.out_char, got.last);
    end else begin
      want = expected_chars.pop_front();
      if (got.out_char !== want.out_char || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: mismatch out_char exp %02h got %02h, last exp %b got %b",
                   $realtime, want.out_char, got.out_char, want.last, got.last);
      end
      if (want.out_char == SYM_GAP) spaces_seen++;
      else glyphs_seen++;
    end
  endtask

  // Predict on accepted inputs, check accepted results, watch for a hang.
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) check_char(result);
      if (push && !full) decode_beat(item);
      if ((push && !full) || (pop && !empty)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
          $display("morse_text_decoder_core verification failed");
          $finish;
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance, push left high.
  task automatic send_beat(input logic [7:0] ch, input logic we, input logic te);
    while ($urandom_range(99) < send_idle_pct) begin
      push = 1'b0;
      item = text_item_t'($urandom);
      @(negedge clk);
    end
    push = 1'b1;
    item = '{text_char: ch, word_end: we, text_end: te};
    do @(posedge clk); while (full);
    beats_sent++;
    @(negedge clk);
  endtask

  // Flags go on the last symbol only.
  task automatic send_code(input string syms, input logic we, input logic te);
    int i;
    for (i = 0; i < syms.len(); i++) begin
      if (i == syms.len() - 1) send_beat(syms[i], we, te);
      else send_beat(syms[i], 1'b0, 1'b0);
    end
  endtask

  task automatic wait_drained();
    push = 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random_letter();
    string       syms;
    int unsigned k;
    int unsigned n;
    if ($urandom_range(99) < 10) begin
      // noise: any byte with any flags
      send_beat(8'($urandom), 1'($urandom), 1'($urandom));
      return;
    end
    k = $urandom_range(CODE_COUNT);
    if (k < CODE_COUNT) begin
      syms = morse_pattern[k];
    end else begin
      syms = "";
      repeat ($urandom_range(7, 1)) begin
        if ($urandom_range(1)) syms = {syms, "-"};
        else syms = {syms, "."};
      end
    end
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        send_code(syms, 1'b0, 1'b0);
        send_beat(SYM_GAP, 1'b0, 1'b0);
      end
      4, 5: send_code(syms, 1'b1, 1'b0);
      6:    send_code(syms, 1'($urandom), 1'b1);
      7: begin
        send_code(syms, 1'b0, 1'b0);
        send_beat(SYM_GAP, 1'b1, 1'($urandom));
      end
      8: begin
        send_code(syms, 1'b0, 1'b0);
        n = $urandom_range(3, 2);
        repeat (n) send_beat(SYM_GAP, 1'b0, 1'b0);
      end
      default: begin
        // broken code: a stray character in the middle
        send_code(syms, 1'b0, 1'b0);
        send_beat(8'($urandom), 1'b0, 1'b0);
        send_code(syms, 1'b1, 1'b0);
      end
    endcase
  endtask

  task automatic test_directed();
    send_code(".-", 1'b0, 1'b0);          // a, closed by a gap
    send_beat(SYM_GAP, 1'b0, 1'b0);
    send_beat(SYM_DASH, 1'b1, 1'b0);      // t on the closing dash, then a space
    send_beat(SYM_GAP, 1'b0, 1'b0);       // empty code gives nothing
    send_code("--..--", 1'b0, 1'b1);      // comma at text end, no space
    send_code("-------", 1'b1, 1'b0);     // overlong: space only
    send_beat(8'hff, 1'b1, 1'b0);         // poison with word end: space only
    send_beat(8'h00, 1'b0, 1'b1);         // text end without word end, no code
    send_beat(SYM_DOT, 1'b1, 1'b1);       // e, both flags
    send_code("..--", 1'b0, 1'b1);        // unknown code dropped
  endtask

  task automatic test_random_phase(input int unsigned beats, input int unsigned s_idle,
                                   input int unsigned r_idle);
    int unsigned stop_at;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    stop_at = beats_sent + beats;
    while (beats_sent < stop_at) send_random_letter();
  endtask

  task automatic test_drain_pause();
    repeat (12) send_random_letter();
    wait_drained();
    repeat (12) send_random_letter();
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst = 1'b0;
    send_idle_pct = 32;
    recv_idle_pct = 45;
    test_directed();
    test_random_phase(300, 32, 45);
    test_drain_pause();
    test_random_phase(300, 45, 32);
    test_random_phase(300, 0, 0);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d input beats, %0d decoded characters and %0d word spaces",
             beats_sent, glyphs_seen, spaces_seen);
    $display("mismatches %0d, expectations left %0d", mismatches, expected_chars.size());
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("morse_text_decoder_core verification clean");
    end else begin
      $display("morse_text_decoder_core verification failed");
    end
    $finish;
  end

endmodule
